>>> design/gbns_pkg.sv
package gbns_pkg;

	localparam int SEQ_BITS   = 16;
	localparam int MAX_WINDOW = 32;
	localparam int WIN_W      = 6;
	localparam int SW         = ((SEQ_BITS > 16) ? SEQ_BITS : 16) + 2;

	localparam logic [WIN_W-1:0] THRESH_RESET = WIN_W'(16);

	typedef logic signed [SW-1:0] seq_t;

	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_ACK     = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	localparam logic CFG_TOTAL  = 1'b0;
	localparam logic CFG_THRESH = 1'b1;

	typedef enum logic [1:0] {
		OP_START,
		OP_ACK,
		OP_TIMEOUT,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		KIND_SEND,
		KIND_RESEND,
		KIND_FIN,
		KIND_STATUS
	} kind_t;

	typedef struct packed {
		op_t                op;
		logic signed [16:0] ackno;
	} cmd_t;

	function automatic seq_t ext_total(input logic [15:0] v);
		return $signed({{(SW-16){1'b0}}, v});
	endfunction

	function automatic seq_t ext_base(input logic [SEQ_BITS-1:0] v);
		return $signed({{(SW-SEQ_BITS){1'b0}}, v});
	endfunction

	function automatic logic [15:0] seq_out(input seq_t s);
		logic [SEQ_BITS-1:0] m;
		m = s[SEQ_BITS-1:0];
		return 16'(m);
	endfunction

endpackage

>>> design/gbns_in_if.sv
interface gbns_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [16:0] ackno;

	modport source (output valid, output func, output ackno, input ready);
	modport sink (input valid, input func, input ackno, output ready);
endinterface

>>> design/gbns_out_if.sv
interface gbns_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] seqno;
	logic [5:0]  window;
	logic [5:0]  slow_threshold;
	logic        timed_out;
	logic        done_res;
	logic        last;

	modport source (output valid, output kind, output seqno, output window,
		output slow_threshold, output timed_out, output done_res, output last,
		input ready);
	modport sink (input valid, input kind, input seqno, input window,
		input slow_threshold, input timed_out, input done_res, input last,
		output ready);
endinterface

>>> design/gbns_front.sv
module gbns_front (
	input  logic          clk,
	input  logic          arst_n,
	gbns_in_if.sink       in_ch,
	output gbns_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);
	import gbns_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	op_t        op_dec;

	always_comb begin
		unique case (in_ch.func)
			FUNC_START:   op_dec = OP_START;
			FUNC_ACK:     op_dec = OP_ACK;
			FUNC_TIMEOUT: op_dec = OP_TIMEOUT;
			default:      op_dec = OP_NOP;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign cmd_valid   = (cnt_q != 2'd0);
	assign cmd         = q_q[rp_q];
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{op: op_dec, ackno: in_ch.ackno};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end
endmodule

>>> design/gbns_back.sv
module gbns_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    total_packets,
	input  logic [5:0]     initial_threshold,
	input  gbns_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	gbns_out_if.source     out_ch
);
	import gbns_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SEND,
		ST_FIN,
		ST_STATUS
	} state_t;

	state_t              state_q;
	logic [SEQ_BITS-1:0] base_q;
	logic [WIN_W-1:0]    win_q;
	logic [WIN_W-1:0]    thresh_q;
	seq_t                last_q;
	seq_t                high_q;
	seq_t                final_q;
	logic                final_valid_q;
	logic                roll_q;
	logic                fin_q;
	logic                tout_q;
	seq_t                s_q;
	seq_t                lim_q;

	logic                ov_q;
	kind_t               o_kind_q;
	logic [15:0]         o_seq_q;
	logic [WIN_W-1:0]    o_win_q;
	logic [WIN_W-1:0]    o_thr_q;
	logic                o_tout_q;
	logic                o_done_q;
	logic                o_last_q;

	logic                emit_ok;
	logic                load_out;
	seq_t                ack_ext;
	seq_t                base_ext;
	seq_t                next_last;
	logic [WIN_W:0]      grown;
	logic [WIN_W-1:0]    win_grown;
	logic [WIN_W-1:0]    half_win;

	assign emit_ok   = !ov_q || out_ch.ready;
	assign load_out  = emit_ok && ((state_q == ST_SEND && s_q < lim_q
		&& s_q < ext_total(total_packets)) || state_q == ST_FIN || state_q == ST_STATUS);
	assign cmd_ready = (state_q == ST_IDLE);
	assign ack_ext   = seq_t'(cmd.ackno);
	assign base_ext  = ext_base(base_q);
	assign next_last = last_q + seq_t'(1);
	assign grown     = {1'b0, win_q} + ((win_q < thresh_q) ? {1'b0, win_q} : (WIN_W+1)'(1));
	assign win_grown = (grown > (WIN_W+1)'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
		: grown[WIN_W-1:0];
	assign half_win  = ((win_q >> 1) == '0) ? WIN_W'(1) : (win_q >> 1);

	assign out_ch.valid          = ov_q;
	assign out_ch.kind           = o_kind_q;
	assign out_ch.seqno          = o_seq_q;
	assign out_ch.window         = o_win_q;
	assign out_ch.slow_threshold = o_thr_q;
	assign out_ch.timed_out      = o_tout_q;
	assign out_ch.done_res       = o_done_q;
	assign out_ch.last           = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			base_q        <= '0;
			win_q         <= WIN_W'(1);
			thresh_q      <= THRESH_RESET;
			last_q        <= '1;
			high_q        <= '1;
			final_q       <= '1;
			final_valid_q <= 1'b0;
			roll_q        <= 1'b0;
			fin_q         <= 1'b0;
			tout_q        <= 1'b0;
			s_q           <= '0;
			lim_q         <= '0;
			ov_q          <= 1'b0;
			o_kind_q      <= KIND_STATUS;
			o_seq_q       <= '0;
			o_win_q       <= '0;
			o_thr_q       <= '0;
			o_tout_q      <= 1'b0;
			o_done_q      <= 1'b0;
			o_last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						priority if (cmd.op == OP_START) begin
							tout_q        <= 1'b0;
							base_q        <= '0;
							win_q         <= WIN_W'(1);
							thresh_q      <= initial_threshold;
							last_q        <= '1;
							high_q        <= '1;
							final_q       <= '1;
							final_valid_q <= 1'b0;
							roll_q        <= 1'b0;
							fin_q         <= 1'b0;
							state_q       <= ST_SETUP;
						end else if (cmd.op == OP_ACK && !fin_q) begin
							tout_q <= 1'b0;
							roll_q <= 1'b0;
							if (final_valid_q && ack_ext == final_q) begin
								fin_q   <= 1'b1;
								state_q <= ST_FIN;
							end else begin
								if (ack_ext == base_ext) begin
									win_q  <= win_grown;
									base_q <= base_q + SEQ_BITS'(1);
								end
								state_q <= ST_SETUP;
							end
						end else if (cmd.op == OP_TIMEOUT && !fin_q) begin
							thresh_q <= half_win;
							win_q    <= WIN_W'(1);
							roll_q   <= 1'b1;
							tout_q   <= 1'b1;
							state_q  <= ST_SETUP;
						end else begin
							tout_q  <= 1'b0;
							state_q <= ST_STATUS;
						end
					end
				end
				ST_SETUP: begin
					s_q     <= (roll_q || next_last < base_ext) ? base_ext : next_last;
					lim_q   <= base_ext + ext_base(SEQ_BITS'(win_q));
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (emit_ok) begin
						priority if (s_q >= lim_q) begin
							state_q <= ST_STATUS;
						end else if (s_q >= ext_total(total_packets)) begin
							final_q       <= s_q - seq_t'(1);
							final_valid_q <= 1'b1;
							state_q       <= ST_STATUS;
						end else begin
							o_kind_q <= (s_q <= high_q) ? KIND_RESEND : KIND_SEND;
							o_seq_q  <= seq_out(s_q);
							o_win_q  <= win_q;
							o_thr_q  <= thresh_q;
							o_tout_q <= tout_q;
							o_done_q <= fin_q;
							o_last_q <= 1'b0;
							last_q   <= s_q;
							if (s_q > high_q) begin
								high_q <= s_q;
							end
							s_q <= s_q + seq_t'(1);
						end
					end
				end
				ST_FIN: begin
					if (emit_ok) begin
						o_kind_q <= KIND_FIN;
						o_seq_q  <= '0;
						o_win_q  <= win_q;
						o_thr_q  <= thresh_q;
						o_tout_q <= tout_q;
						o_done_q <= fin_q;
						o_last_q <= 1'b0;
						state_q  <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (emit_ok) begin
						o_kind_q <= KIND_STATUS;
						o_seq_q  <= '0;
						o_win_q  <= win_q;
						o_thr_q  <= thresh_q;
						o_tout_q <= tout_q;
						o_done_q <= fin_q;
						o_last_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> design/go_back_n_sender_window_top.sv
// Each request is queued, then taken by the idle sequencer, which walks setup, send and status
// for a send pass (at most 32 data items), fin then status for a fin, or status alone; each
// item is registered in the output register, and output stalls hold the sequencer. A two-entry
// request queue lets new requests enter while a previous event is still being sent.
// Reset (arst_n low, asynchronous): base 0, window 1, threshold 16, no packets sent,
// total_packets 0, initial_threshold 16, queue and output register empty.
module go_back_n_sender_window_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_data,
	gbns_in_if.sink             in_ch,
	gbns_out_if.source          out_ch
);
	import gbns_pkg::*;

	logic [15:0] total_q;
	logic [5:0]  ithr_q;
	cmd_t        cmd;
	logic        cmd_valid;
	logic        cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ithr_q  <= THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TOTAL:  total_q <= cfg_data;
				CFG_THRESH: ithr_q  <= cfg_data[5:0];
				default:    total_q <= total_q;
			endcase
		end
	end

	gbns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	gbns_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.total_packets     (total_q),
		.initial_threshold (ithr_q),
		.cmd               (cmd),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.out_ch            (out_ch)
	);

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last == (out_ch.kind == KIND_STATUS)))
		else $error("last flag and status kind disagree");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_FIN |-> out_ch.done_res)
		else $error("fin item without done");

	a_busy_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("sequencer took a request while busy");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.window != '0 && out_ch.window <= 6'(MAX_WINDOW)))
		else $error("window out of range");
endmodule
